// ----- rtl/core/orf_pkg.sv -----
// Shared constants and transaction types for the overwrite ring FIFO.
package orf_pkg;

    localparam int Depth    = 256;
    localparam int PtrW     = $clog2(Depth);
    localparam int DataW    = 8;
    localparam int SizeLogW = 4;

    localparam logic [SizeLogW-1:0] SizeLogMin   = 4'd1;
    localparam logic [SizeLogW-1:0] SizeLogMax   = 4'd8;
    localparam logic [SizeLogW-1:0] SizeLogReset = 4'd8;

    // action codes; the fourth code is a no-op
    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [1:0] ACT_PEEK    = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [DataW-1:0] write_data;
        logic [7:0]       peek_offset;
    } cmd_t;

    typedef struct packed {
        logic [DataW-1:0] read_data;
        logic             success;
        logic             dropped_oldest;
        logic [7:0]       item_count;
    } result_t;

endpackage

// ----- rtl/core/overwrite_ring_fifo.sv -----
// Overwrite-oldest byte ring FIFO with a synchronous storage memory.
//
// Command-style byte FIFO. A transaction (enqueue, dequeue or peek) is taken
// at every rising edge where start is high; busy never rises, so one
// transaction per clock is sustained. Each transaction yields exactly one
// result, shown on res for one cycle with done high, in the cycle after it
// was taken; the storage memory has a registered read port and is read
// at the edge the transaction is taken. The receiver cannot stall, so it must
// capture res whenever done is high. The ring holds 2^size_log2 - 1 bytes;
// an enqueue into a full ring drops the oldest byte and reports it.
// Dequeue of an empty ring and a peek at an offset not below the count fail
// with read_data zero. Writing size_log2 (values clamp to 1..8) empties the
// ring; write it only while no transaction is in flight. Reading a storage
// entry is always preceded by its enqueue, so the memory needs no clearing.
module overwrite_ring_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  orf_pkg::cmd_t                 cmd,
    output logic                          done,
    output orf_pkg::result_t              res,
    input  logic                          cfg_we,
    input  logic [orf_pkg::SizeLogW-1:0]  cfg_wdata
);
    import orf_pkg::*;

    // storage memory: one write port, one registered read port
    logic [DataW-1:0] mem [Depth];
    logic [DataW-1:0] mem_q;

    logic [SizeLogW-1:0] size_log2_reg;
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;

    // result stage
    logic       done_reg;
    logic       use_mem_reg, use_mem_next;
    logic       success_reg, success_next;
    logic       dropped_reg, dropped_next;
    logic [7:0] count_reg;

    logic [SizeLogW-1:0] size_eff;
    logic [PtrW-1:0]     mask;
    logic [PtrW-1:0]     count;
    logic [PtrW-1:0]     count_after;
    logic [PtrW-1:0]     rd_addr;
    logic                accept;
    logic                mem_we;
    logic                mem_re;

    assign accept = start && !busy;
    // memory read latency is fully pipelined, no interlock needed
    assign busy   = 1'b0;

    // clamp size to the supported range
    always_comb
    begin
        if (size_log2_reg < SizeLogMin)
            size_eff = SizeLogMin;
        else if (size_log2_reg > SizeLogMax)
            size_eff = SizeLogMax;
        else
            size_eff = size_log2_reg;
    end

    assign mask  = PtrW'((9'd1 << size_eff) - 9'd1);
    assign count = (wr_ptr_reg - rd_ptr_reg) & mask;

    // per-transaction decode
    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        use_mem_next = 1'b0;
        success_next = 1'b0;
        dropped_next = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        rd_addr      = rd_ptr_reg;
        case (cmd.action)
            ACT_ENQUEUE:
            begin
                if (count == mask)
                begin
                    rd_ptr_next  = (rd_ptr_reg + 1'b1) & mask;
                    dropped_next = 1'b1;
                end
                mem_we       = 1'b1;
                wr_ptr_next  = (wr_ptr_reg + 1'b1) & mask;
                success_next = 1'b1;
            end
            ACT_DEQUEUE:
            begin
                if (count != '0)
                begin
                    mem_re       = 1'b1;
                    rd_ptr_next  = (rd_ptr_reg + 1'b1) & mask;
                    use_mem_next = 1'b1;
                    success_next = 1'b1;
                end
            end
            ACT_PEEK:
            begin
                if (PtrW'(cmd.peek_offset) < count)
                begin
                    mem_re       = 1'b1;
                    rd_addr      = (rd_ptr_reg + PtrW'(cmd.peek_offset)) & mask;
                    use_mem_next = 1'b1;
                    success_next = 1'b1;
                end
            end
            default:
            begin
                // unused code: no state change
            end
        endcase
    end

    assign count_after = (wr_ptr_next - rd_ptr_next) & mask;

    // storage memory; a write and a read never target one transaction
    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
            mem[wr_ptr_reg] <= cmd.write_data;
        if (accept && mem_re)
            mem_q <= mem[rd_addr];
    end

    // pointers, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SizeLogReset;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            done_reg      <= 1'b0;
            use_mem_reg   <= 1'b0;
            success_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            done_reg <= accept;
            if (cfg_we)
            begin
                size_log2_reg <= cfg_wdata;
                wr_ptr_reg    <= '0;
                rd_ptr_reg    <= '0;
            end
            else if (accept)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
            end
            if (accept)
            begin
                use_mem_reg <= use_mem_next;
                success_reg <= success_next;
                dropped_reg <= dropped_next;
                count_reg   <= 8'(count_after);
            end
        end
    end

    assign done               = done_reg;
    assign res.read_data      = use_mem_reg ? mem_q : '0;
    assign res.success        = success_reg;
    assign res.dropped_oldest = dropped_reg;
    assign res.item_count     = count_reg;

`ifndef ASSERT_OFF
    // a result only follows a taken transaction
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result without a taken transaction");

    // pointers always stay inside the active ring
    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ((wr_ptr_reg & ~mask) == '0) && ((rd_ptr_reg & ~mask) == '0))
        else $error("pointer outside active ring");

    // an enqueue into a full ring drops the oldest byte, and count stays full
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we && (cmd.action == ACT_ENQUEUE) && (count == mask)
        |=> done && res.dropped_oldest && (count == mask))
        else $error("full enqueue did not drop oldest");

    // a read result was fetched from memory only on success
    a_mem_only_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        done && use_mem_reg |-> res.success && !res.dropped_oldest)
        else $error("memory data on a failed or enqueue result");

    // enqueue advances the write pointer by one within the ring
    a_enq_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we && (cmd.action == ACT_ENQUEUE)
        |=> wr_ptr_reg == (($past(wr_ptr_reg) + 1'b1) & mask))
        else $error("enqueue did not advance write pointer");
`endif

endmodule

// ----- tb/tb_overwrite_ring_fifo.sv -----
// Self-checking testbench for the overwrite-oldest byte ring FIFO.
module tb_overwrite_ring_fifo;

    import orf_pkg::*;

    // unnamed fourth action code: block must leave the ring alone
    localparam logic [1:0] ACT_NOP = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    // result arrives in the cycle after its transaction; spare cycles on drain
    localparam int SETTLE_CYCLES = 3;
    localparam int NUM_PHASES    = 10;
    localparam int MAX_REPORTS   = 40;

    // ring sizes per random phase; phases 7 and 8 draw a size at run time
    localparam logic [3:0] PHASE_SIZE [NUM_PHASES] =
        '{4'd8, 4'd1, 4'd3, 4'd0, 4'd2, 4'd15, 4'd4, 4'd5, 4'd6, 4'd6};

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t res;
    logic    cfg_we;
    logic [SizeLogW-1:0] cfg_wdata;

    overwrite_ring_fifo u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the ring: storage, both pointers and the size register.
    // ------------------------------------------------------------------
    logic [7:0]          ring_mem [Depth];
    logic [7:0]          head_ptr;
    logic [7:0]          tail_ptr;
    logic [SizeLogW-1:0] size_sel;

    // results owed by the block, oldest first
    result_t pending_results [$];

    int fail_count;
    int n_enq, n_deq, n_peek, n_nop, n_drop, n_miss, n_cfg;
    int unsigned cycle_count;

    // Directed table. Rows either write the size register or issue one
    // transaction; "typed" rows carry a result read straight off the spec,
    // the rest are checked against the shadow ring.
    typedef struct packed {
        logic                is_cfg;
        logic [SizeLogW-1:0] cfg_val;
        cmd_t                op;
        logic                typed;
        result_t             want;
    } dir_row_t;

    localparam int NUM_DIR = 26;

    //    cfg   size   action       wdata  offset  typed  rdata  ok    drop  count
    dir_row_t dir_rows [NUM_DIR] = '{
        // fresh after reset: empty ring, size_log2 of 8 (255 bytes)
        {1'b0, 4'd0,  ACT_DEQUEUE, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_PEEK,    8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_NOP,     8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 8'd0},
        // smallest ring holds a single byte
        {1'b1, 4'd1,  ACT_ENQUEUE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 8'd1},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b1, 8'd1},
        {1'b0, 4'd0,  ACT_PEEK,    8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 8'd1},
        {1'b0, 4'd0,  ACT_PEEK,    8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 8'd1},
        {1'b0, 4'd0,  ACT_DEQUEUE, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_DEQUEUE, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 8'd0},
        // size below range clamps to the smallest ring
        {1'b1, 4'd0,  ACT_ENQUEUE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'hA5, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 8'd1},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'h5A, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1, 8'd1},
        {1'b0, 4'd0,  ACT_PEEK,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        // size above range clamps to the full ring
        {1'b1, 4'd15, ACT_ENQUEUE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'h3C, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 8'd1},
        {1'b0, 4'd0,  ACT_NOP,     8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 8'd1},
        {1'b0, 4'd0,  ACT_PEEK,    8'h00, 8'h00, 1'b1, 8'h3C, 1'b1, 1'b0, 8'd1},
        // three-byte ring (size_log2 2): fill, overwrite, peek at and past the edge
        {1'b1, 4'd2,  ACT_ENQUEUE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'h02, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'h03, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_ENQUEUE, 8'h04, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_PEEK,    8'h00, 8'h02, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_PEEK,    8'h00, 8'h03, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0},
        {1'b0, 4'd0,  ACT_DEQUEUE, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0}
    };

    // Pointer mask for the current size; out-of-range sizes clamp to 1..8.
    function automatic logic [7:0] ring_mask();
        logic [SizeLogW-1:0] k;
        k = size_sel;
        if (k < SizeLogMin)
        begin
            k = SizeLogMin;
        end
        if (k > SizeLogMax)
        begin
            k = SizeLogMax;
        end
        return 8'((9'd1 << k) - 9'd1);
    endfunction

    // Apply one transaction to the shadow ring and return what the block owes.
    function automatic result_t fifo_step(cmd_t c);
        logic [7:0] mask;
        logic [7:0] fill;
        result_t    r;
        mask = ring_mask();
        fill = (head_ptr - tail_ptr) & mask;
        r    = '0;
        case (c.action)
            ACT_ENQUEUE:
            begin
                // full ring: the oldest byte goes first
                if (fill == mask)
                begin
                    tail_ptr         = (tail_ptr + 8'd1) & mask;
                    r.dropped_oldest = 1'b1;
                end
                ring_mem[head_ptr] = c.write_data;
                head_ptr           = (head_ptr + 8'd1) & mask;
                r.success          = 1'b1;
            end
            ACT_DEQUEUE:
            begin
                if (fill != 8'd0)
                begin
                    r.read_data = ring_mem[tail_ptr];
                    tail_ptr    = (tail_ptr + 8'd1) & mask;
                    r.success   = 1'b1;
                end
            end
            ACT_PEEK:
            begin
                if (c.peek_offset < fill)
                begin
                    r.read_data = ring_mem[(tail_ptr + c.peek_offset) & mask];
                    r.success   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.item_count = (head_ptr - tail_ptr) & mask;
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        else if (roll < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // Present one transaction, hold it until taken, then idle for the requested gap.
    // start stays high across back-to-back transactions.
    task automatic send_cmd(input cmd_t c, input logic typed, input result_t typed_res,
                            input int gap);
        result_t r;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        r = fifo_step(c);
        pending_results.push_back(typed ? typed_res : r);
        case (c.action)
            ACT_ENQUEUE: n_enq++;
            ACT_DEQUEUE: n_deq++;
            ACT_PEEK:    n_peek++;
            default:     n_nop++;
        endcase
        if (r.dropped_oldest)
        begin
            n_drop++;
        end
        if (c.action inside {ACT_DEQUEUE, ACT_PEEK} && !r.success)
        begin
            n_miss++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop issuing and wait until every owed result has come back.
    task automatic drain();
        if (start)
        begin
            start <= 1'b0;
        end
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Size writes happen only on an idle block; they empty the ring.
    task automatic write_size(input logic [SizeLogW-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_sel = v;
        head_ptr = 8'd0;
        tail_ptr = 8'd0;
        n_cfg++;
    endtask

    task automatic flag_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: done is sampled at the edge that ends its cycle and may
    // stay high across back-to-back results; each is matched against the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: result with nothing outstanding, got %0h", $time, res);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.read_data !== want.read_data)
                begin
                    flag_field("read_data", want.read_data, res.read_data);
                end
                if (res.success !== want.success)
                begin
                    flag_field("success", 8'(want.success), 8'(res.success));
                end
                if (res.dropped_oldest !== want.dropped_oldest)
                begin
                    flag_field("dropped_oldest", 8'(want.dropped_oldest),
                               8'(res.dropped_oldest));
                end
                if (res.item_count !== want.item_count)
                begin
                    flag_field("item_count", want.item_count, res.item_count);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_overwrite_ring_fifo failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random phases, one ring size each.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        cmd_t          c;
        logic [7:0]    fill;
        logic [7:0]    mask;
        logic [3:0]    sz;
        logic          big;
        logic          steady;
        int            n_items;
        int            roll;

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        fail_count  = 0;
        head_ptr    = 8'd0;
        tail_ptr    = 8'd0;
        size_sel    = SizeLogReset;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                write_size(dir_rows[i].cfg_val);
            end
            else
            begin
                send_cmd(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want, pick_gap());
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            sz = (p == 7 || p == 8) ? 4'($urandom_range(1, 7)) : PHASE_SIZE[p];
            write_size(sz);
            mask = ring_mask();
            // full-size rings are enqueue-heavy and long enough to fill and wrap
            big     = (mask == 8'hFF);
            n_items = big ? 300 : 50;
            // about one phase in four runs with no pauses at all
            steady  = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n_items; i++)
            begin
                // let the pipe run dry once, mid-way through phase 3
                if (p == 3 && i == n_items / 2)
                begin
                    drain();
                end
                fill          = (head_ptr - tail_ptr) & mask;
                roll          = $urandom_range(0, 99);
                c.write_data  = 8'($urandom_range(0, 255));
                c.peek_offset = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                              : 8'($urandom_range(0, (fill == 8'hFF) ? 255 : fill + 1));
                if (roll < (big ? 95 : 45))
                begin
                    c.action = ACT_ENQUEUE;
                end
                else if (roll < (big ? 97 : 72))
                begin
                    c.action = ACT_DEQUEUE;
                end
                else if (roll < (big ? 99 : 95))
                begin
                    c.action = ACT_PEEK;
                end
                else
                begin
                    c.action = ACT_NOP;
                end
                send_cmd(c, 1'b0, '0, steady ? 0 : pick_gap());
            end
        end

        drain();
        if (pending_results.size() != 0)
        begin
            fail_count += pending_results.size();
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("covered %0d transactions: %0d enqueue, %0d dequeue, %0d peek, %0d no-op",
                 n_enq + n_deq + n_peek + n_nop, n_enq, n_deq, n_peek, n_nop);
        $display("%0d size writes, %0d oldest-byte overwrites, %0d empty/out-of-range reads",
                 n_cfg, n_drop, n_miss);
        if (fail_count == 0)
        begin
            $display("tb_overwrite_ring_fifo passed");
        end
        else
        begin
            $display("tb_overwrite_ring_fifo failed");
        end
        $finish;
    end

endmodule
